// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL core (complex_integer_alu_core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked outside reset.
`define CIALU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked on every edge, reset included.
`define CIALU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CIALU_ASSERT(lbl, clk, rstn, prop, msg)
`define CIALU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/cialu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cialu_pkg
// Types and constants of the complex integer arithmetic unit.
// ----------------------------------------------------------------------------
package cialu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FIELD_W    = 32;
    localparam int OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // per-word control carried down the divider row
    typedef struct packed {
        logic div;
        logic dz;
        logic neg_re;
        logic neg_im;
    } ctrl_t;

endpackage

// ===== src/cialu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cialu_front
// Operand load, products and sums; prepares magnitudes for the divider row.
// ----------------------------------------------------------------------------
module cialu_front #(
    parameter int W = cialu_pkg::DATA_WIDTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cialu_pkg::op_t               in_op,
    input  logic [cialu_pkg::FIELD_W-1:0] in_a,
    input  logic [cialu_pkg::FIELD_W-1:0] in_b,
    input  logic [cialu_pkg::FIELD_W-1:0] in_c,
    input  logic [cialu_pkg::FIELD_W-1:0] in_d,
    output logic                         out_valid,
    input  logic                         out_ready,
    output cialu_pkg::ctrl_t             out_ctrl,
    output logic [W-1:0]                 out_den,
    output logic [W-1:0]                 out_nq_re,
    output logic [W-1:0]                 out_nq_im
);

    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    cialu_pkg::op_t op1_reg, op2_reg;
    logic [W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [W-1:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    logic [W-1:0] as_re_reg, as_im_reg;
    logic [W-1:0] a_next, b_next, c_next, d_next;
    logic [W-1:0] ac_next, bd_next, ad_next, bc_next, cc_next, dd_next;
    logic [W-1:0] as_re_next, as_im_next;
    logic [W-1:0] den_next, nr_next, ni_next, re_next, im_next;
    logic [W-1:0] den_abs, nr_abs, ni_abs;
    cialu_pkg::ctrl_t ctrl_next;
    cialu_pkg::ctrl_t ctrl_reg;
    logic [W-1:0] den_reg, nq_re_reg, nq_im_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // sign-extend or truncate the 32-bit fields to the working width
    assign a_next = W'($signed(in_a));
    assign b_next = W'($signed(in_b));
    assign c_next = W'($signed(in_c));
    assign d_next = W'($signed(in_d));

    assign ac_next = a_reg * c_reg;
    assign bd_next = b_reg * d_reg;
    assign ad_next = a_reg * d_reg;
    assign bc_next = b_reg * c_reg;
    assign cc_next = c_reg * c_reg;
    assign dd_next = d_reg * d_reg;

    always_comb begin
        if (op1_reg == cialu_pkg::OP_SUB) begin
            as_re_next = a_reg - c_reg;
            as_im_next = b_reg - d_reg;
        end else begin
            as_re_next = a_reg + c_reg;
            as_im_next = b_reg + d_reg;
        end
    end

    assign den_next = cc_reg + dd_reg;
    assign nr_next  = ac_reg + bd_reg;
    assign ni_next  = bc_reg - ad_reg;
    assign den_abs  = den_next[W-1] ? W'(0) - den_next : den_next;
    assign nr_abs   = nr_next[W-1]  ? W'(0) - nr_next  : nr_next;
    assign ni_abs   = ni_next[W-1]  ? W'(0) - ni_next  : ni_next;

    always_comb begin
        ctrl_next = '0;
        re_next   = as_re_reg;
        im_next   = as_im_reg;
        case (op2_reg)
            cialu_pkg::OP_ADD, cialu_pkg::OP_SUB: begin
                re_next = as_re_reg;
                im_next = as_im_reg;
            end
            cialu_pkg::OP_MUL: begin
                re_next = ac_reg - bd_reg;
                im_next = ad_reg + bc_reg;
            end
            cialu_pkg::OP_DIV: begin
                if (den_next == '0) begin
                    ctrl_next.dz = 1'b1;
                    re_next      = '0;
                    im_next      = '0;
                end else begin
                    ctrl_next.div    = 1'b1;
                    ctrl_next.neg_re = nr_next[W-1] ^ den_next[W-1];
                    ctrl_next.neg_im = ni_next[W-1] ^ den_next[W-1];
                    re_next          = nr_abs;
                    im_next          = ni_abs;
                end
            end
            default: begin
                re_next = as_re_reg;
                im_next = as_im_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            op1_reg <= in_op;
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
            d_reg   <= d_next;
        end
        if (rdy2 && v1_reg) begin
            op2_reg   <= op1_reg;
            ac_reg    <= ac_next;
            bd_reg    <= bd_next;
            ad_reg    <= ad_next;
            bc_reg    <= bc_next;
            cc_reg    <= cc_next;
            dd_reg    <= dd_next;
            as_re_reg <= as_re_next;
            as_im_reg <= as_im_next;
        end
        if (rdy3 && v2_reg) begin
            ctrl_reg  <= ctrl_next;
            den_reg   <= den_abs;
            nq_re_reg <= re_next;
            nq_im_reg <= im_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_den   = den_reg;
    assign out_nq_re = nq_re_reg;
    assign out_nq_im = nq_im_reg;

endmodule

// ===== src/cialu_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cialu_div_cell
// One restoring division step for both quotients; passes other words through.
// ----------------------------------------------------------------------------
module cialu_div_cell #(
    parameter int W = cialu_pkg::DATA_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  cialu_pkg::ctrl_t in_ctrl,
    input  logic [W-1:0]     in_den,
    input  logic [W-1:0]     in_rem_re,
    input  logic [W-1:0]     in_rem_im,
    input  logic [W-1:0]     in_nq_re,
    input  logic [W-1:0]     in_nq_im,
    output logic             out_valid,
    input  logic             out_ready,
    output cialu_pkg::ctrl_t out_ctrl,
    output logic [W-1:0]     out_den,
    output logic [W-1:0]     out_rem_re,
    output logic [W-1:0]     out_rem_im,
    output logic [W-1:0]     out_nq_re,
    output logic [W-1:0]     out_nq_im
);

    logic             valid_reg;
    cialu_pkg::ctrl_t ctrl_reg;
    logic [W-1:0]     den_reg, rem_re_reg, rem_im_reg, nq_re_reg, nq_im_reg;
    logic [W-1:0]     rem_re_next, rem_im_next, nq_re_next, nq_im_next;
    logic [W:0]       sh_re, sh_im, dif_re, dif_im;

    assign in_ready = !valid_reg || out_ready;

    // shift in the next numerator bit, subtract where it fits
    assign sh_re  = {in_rem_re, in_nq_re[W-1]};
    assign sh_im  = {in_rem_im, in_nq_im[W-1]};
    assign dif_re = sh_re - {1'b0, in_den};
    assign dif_im = sh_im - {1'b0, in_den};

    always_comb begin
        rem_re_next = in_rem_re;
        rem_im_next = in_rem_im;
        nq_re_next  = in_nq_re;
        nq_im_next  = in_nq_im;
        if (in_ctrl.div) begin
            rem_re_next = dif_re[W] ? sh_re[W-1:0] : dif_re[W-1:0];
            rem_im_next = dif_im[W] ? sh_im[W-1:0] : dif_im[W-1:0];
            nq_re_next  = {in_nq_re[W-2:0], !dif_re[W]};
            nq_im_next  = {in_nq_im[W-2:0], !dif_im[W]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctrl_reg   <= in_ctrl;
            den_reg    <= in_den;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            nq_re_reg  <= nq_re_next;
            nq_im_reg  <= nq_im_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ctrl   = ctrl_reg;
    assign out_den    = den_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_nq_re  = nq_re_reg;
    assign out_nq_im  = nq_im_reg;

endmodule

// ===== src/complex_integer_alu_core.sv =====
`timescale 1ns / 1ps
// A word passes through the front stages, the row of DATA_WIDTH divider cells and the output register.
// Throughput: one word per cycle while m_tready takes the results; the row of DATA_WIDTH divider cells, one
// quotient bit each, keeps every operation in the same pipeline.
// Each stage holds its word while the stage below is full and stalled, so bubbles close up.
// Reset (aresetn low, synchronous) empties every stage; no other state is reset.
// ----------------------------------------------------------------------------
// complex_integer_alu_core
// Complex add, subtract, multiply and truncating divide on streamed words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module complex_integer_alu_core #(
    parameter int DATA_WIDTH = cialu_pkg::DATA_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_real[31:0], a_imag[63:32], b_real[95:64], b_imag[127:96]
    input  logic [127:0] s_tdata,
    // operation[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // res_real[31:0], res_imag[63:32]
    output logic [63:0]  m_tdata,
    // div_zero[0]
    output logic [0:0]   m_tuser
);

    localparam int W  = DATA_WIDTH;
    localparam int FW = cialu_pkg::FIELD_W;

    logic             v   [W+1];
    logic             r   [W+1];
    cialu_pkg::ctrl_t ct  [W+1];
    logic [W-1:0]     den [W+1];
    logic [W-1:0]     rre [W+1];
    logic [W-1:0]     rim [W+1];
    logic [W-1:0]     qre [W+1];
    logic [W-1:0]     qim [W+1];

    logic             m_tvalid_reg;
    logic [63:0]      m_tdata_reg;
    logic             dz_reg;
    logic [W-1:0]     res_re_next, res_im_next;

    cialu_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (cialu_pkg::op_t'(s_tuser)),
        .in_a      (s_tdata[FW-1:0]),
        .in_b      (s_tdata[2*FW-1:FW]),
        .in_c      (s_tdata[3*FW-1:2*FW]),
        .in_d      (s_tdata[4*FW-1:3*FW]),
        .out_valid (v[0]),
        .out_ready (r[0]),
        .out_ctrl  (ct[0]),
        .out_den   (den[0]),
        .out_nq_re (qre[0]),
        .out_nq_im (qim[0])
    );

    assign rre[0] = '0;
    assign rim[0] = '0;

    for (genvar i = 0; i < W; i++) begin : g_cell
        cialu_div_cell #(.W(W)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (v[i]),
            .in_ready   (r[i]),
            .in_ctrl    (ct[i]),
            .in_den     (den[i]),
            .in_rem_re  (rre[i]),
            .in_rem_im  (rim[i]),
            .in_nq_re   (qre[i]),
            .in_nq_im   (qim[i]),
            .out_valid  (v[i+1]),
            .out_ready  (r[i+1]),
            .out_ctrl   (ct[i+1]),
            .out_den    (den[i+1]),
            .out_rem_re (rre[i+1]),
            .out_rem_im (rim[i+1]),
            .out_nq_re  (qre[i+1]),
            .out_nq_im  (qim[i+1])
        );
    end

    assign r[W] = !m_tvalid_reg || m_tready;

    // restore quotient signs
    assign res_re_next = ct[W].neg_re ? W'(0) - qre[W] : qre[W];
    assign res_im_next = ct[W].neg_im ? W'(0) - qim[W] : qim[W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (r[W]) begin
            m_tvalid_reg <= v[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (r[W] && v[W]) begin
            m_tdata_reg <= {32'(res_im_next), 32'(res_re_next)};
            dz_reg      <= ct[W].dz;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = dz_reg;

    `CIALU_ASSERT(a_stall_only_full, aclk, aresetn, !s_tready |-> m_tvalid, "stall with empty output")
    `CIALU_ASSERT(a_dz_zero, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata == 64'd0), "divide by zero result not cleared")
    `CIALU_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule
